### rtl/cau_pkg.sv
// Package: widths, operation and status codes, and the saturation function for the complex ALU.
`timescale 1ns / 1ps
package cau_pkg;
   localparam int FracBits = 8;
   localparam int DataW    = 16;
   // numerators carry 33 bits of products plus FracBits of scaling
   localparam int NumW     = 2 * DataW + 1 + FracBits;
   localparam int DenW     = 2 * DataW + 1;
   localparam int QuoW     = NumW;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   // saturate a wide signed value to 16 bits
   function automatic logic [DataW:0] sat16(input logic signed [NumW:0] v);
      logic [DataW:0] r;
      if (v > $signed({{(NumW - DataW + 2){1'b0}}, {(DataW - 1){1'b1}}}))
         r = {1'b1, 1'b0, {(DataW - 1){1'b1}}};
      else if (v < $signed({{(NumW - DataW + 2){1'b1}}, {(DataW - 1){1'b0}}}))
         r = {1'b1, 1'b1, {(DataW - 1){1'b0}}};
      else
         r = {1'b0, v[DataW-1:0]};
      return r;
   endfunction
endpackage

### rtl/complex_arith_unit.sv
// Top level of the complex ALU: add, subtract, multiply, divide in Q8.8 with saturation.
`timescale 1ns / 1ps
// Usage:
//   Raise start with mode and operands on req_*; busy is always low, so a
//   transaction is taken at every edge where start is high.
//   Every transaction yields one result on rsp_res_real, rsp_res_imag and
//   rsp_status, flagged by rsp_valid for exactly one cycle.
//   Every operation passes through the same pipeline depth; throughput
//   is one transaction per cycle. The depth is set by the divider, which
//   resolves one quotient bit per stage over 41 stages; the other operations
//   ride a delay line alongside it so results stay in order.
//   Stages: operand register, products, sums and magnitudes feeding the
//   divider, divider stages, sign fixup and saturation.
//   Reset clears the valid bits only; no result is produced until the
//   first transaction has passed the full pipeline.
//   The receiver cannot stall; results are offered once and dropped after.
module complex_arith_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_mode,
   input  logic signed [15:0] req_a_real,
   input  logic signed [15:0] req_a_imag,
   input  logic signed [15:0] req_b_real,
   input  logic signed [15:0] req_b_imag,
   output logic         rsp_valid,
   output logic signed [15:0] rsp_res_real,
   output logic signed [15:0] rsp_res_imag,
   output logic [1:0]   rsp_status
);
   localparam int NW = cau_pkg::NumW;
   localparam int DL = cau_pkg::QuoW;

   assign busy = 1'b0;

   // stage 1: operands
   logic                       v1_ff;
   cau_pkg::op_type            op1_ff;
   logic signed [15:0]         ar1_ff, ai1_ff, br1_ff, bi1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
      op1_ff <= cau_pkg::op_type'(req_mode);
      ar1_ff <= req_a_real;
      ai1_ff <= req_a_imag;
      br1_ff <= req_b_real;
      bi1_ff <= req_b_imag;
   end

   // stage 2: products and add/sub
   logic                       v2_ff;
   cau_pkg::op_type            op2_ff;
   logic signed [31:0]         arbr_ff, aibi_ff, arbi_ff, aibr_ff, brbr_ff, bibi_ff;
   logic signed [16:0]         sre2_ff, sim2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      op2_ff  <= op1_ff;
      arbr_ff <= ar1_ff * br1_ff;
      aibi_ff <= ai1_ff * bi1_ff;
      arbi_ff <= ar1_ff * bi1_ff;
      aibr_ff <= ai1_ff * br1_ff;
      brbr_ff <= br1_ff * br1_ff;
      bibi_ff <= bi1_ff * bi1_ff;
      if (op1_ff == cau_pkg::OP_SUB) begin
         sre2_ff <= 17'(ar1_ff) - 17'(br1_ff);
         sim2_ff <= 17'(ai1_ff) - 17'(bi1_ff);
      end else begin
         sre2_ff <= 17'(ar1_ff) + 17'(br1_ff);
         sim2_ff <= 17'(ai1_ff) + 17'(bi1_ff);
      end
   end

   // stage 3: sums, result for non-divide, magnitudes for divide
   logic signed [32:0] mre_in, mim_in, nre_in, nim_in;
   logic [32:0]        den_in;
   always_comb begin
      mre_in = 33'(arbr_ff) - 33'(aibi_ff);
      mim_in = 33'(arbi_ff) + 33'(aibr_ff);
      nre_in = 33'(arbr_ff) + 33'(aibi_ff);
      nim_in = 33'(aibr_ff) - 33'(arbi_ff);
      den_in = 33'($unsigned(brbr_ff)) + 33'($unsigned(bibi_ff));
   end

   logic                   v3_ff;
   cau_pkg::op_type        op3_ff;
   logic signed [NW:0]     pre3_ff, pim3_ff;
   logic                   sre3_ff, sim3_ff, dz3_ff;
   logic [NW-1:0]          mgre3_ff, mgim3_ff;
   logic [cau_pkg::DenW-1:0] den3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      op3_ff <= op2_ff;
      if (op2_ff == cau_pkg::OP_MUL) begin
         pre3_ff <= (NW+1)'(mre_in >>> cau_pkg::FracBits);
         pim3_ff <= (NW+1)'(mim_in >>> cau_pkg::FracBits);
      end else begin
         pre3_ff <= (NW+1)'(sre2_ff);
         pim3_ff <= (NW+1)'(sim2_ff);
      end
      sre3_ff  <= nre_in[32];
      sim3_ff  <= nim_in[32];
      mgre3_ff <= NW'(nre_in[32] ? -nre_in : nre_in) << cau_pkg::FracBits;
      mgim3_ff <= NW'(nim_in[32] ? -nim_in : nim_in) << cau_pkg::FracBits;
      den3_ff  <= den_in;
      dz3_ff   <= (den_in == '0);
   end

   logic [cau_pkg::QuoW-1:0] qre, qim;
   cau_div u_div (
      .clock     (clock),
      .num_re_in (mgre3_ff),
      .num_im_in (mgim3_ff),
      .den_in    (den3_ff),
      .quo_re    (qre),
      .quo_im    (qim)
   );

   // delay line alongside the divider
   logic                   vd_ff   [DL];
   cau_pkg::op_type        opd_ff  [DL];
   logic signed [NW:0]     pred_ff [DL];
   logic signed [NW:0]     pimd_ff [DL];
   logic                   sred_ff [DL];
   logic                   simd_ff [DL];
   logic                   dzd_ff  [DL];
   for (genvar s = 0; s < DL; s++) begin : g_dly
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) vd_ff[0] <= 1'b0;
            else       vd_ff[0] <= v3_ff;
            opd_ff[0]  <= op3_ff;
            pred_ff[0] <= pre3_ff;
            pimd_ff[0] <= pim3_ff;
            sred_ff[0] <= sre3_ff;
            simd_ff[0] <= sim3_ff;
            dzd_ff[0]  <= dz3_ff;
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) vd_ff[s] <= 1'b0;
            else       vd_ff[s] <= vd_ff[s-1];
            opd_ff[s]  <= opd_ff[s-1];
            pred_ff[s] <= pred_ff[s-1];
            pimd_ff[s] <= pimd_ff[s-1];
            sred_ff[s] <= sred_ff[s-1];
            simd_ff[s] <= simd_ff[s-1];
            dzd_ff[s]  <= dzd_ff[s-1];
         end
      end
   end

   // final stage: sign fixup and saturation
   logic signed [NW:0] fre_in, fim_in;
   logic [16:0]        satre_in, satim_in;
   always_comb begin
      if (opd_ff[DL-1] == cau_pkg::OP_DIV) begin
         fre_in = sred_ff[DL-1] ? -$signed({1'b0, qre}) : $signed({1'b0, qre});
         fim_in = simd_ff[DL-1] ? -$signed({1'b0, qim}) : $signed({1'b0, qim});
      end else begin
         fre_in = pred_ff[DL-1];
         fim_in = pimd_ff[DL-1];
      end
      satre_in = cau_pkg::sat16(fre_in);
      satim_in = cau_pkg::sat16(fim_in);
   end

   logic               vo_ff;
   logic [15:0]        ore_ff, oim_ff;
   cau_pkg::status_type ost_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= vd_ff[DL-1];
      if (opd_ff[DL-1] == cau_pkg::OP_DIV && dzd_ff[DL-1]) begin
         ore_ff <= '0;
         oim_ff <= '0;
         ost_ff <= cau_pkg::ST_DIV0;
      end else begin
         ore_ff <= satre_in[15:0];
         oim_ff <= satim_in[15:0];
         ost_ff <= (satre_in[16] | satim_in[16]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
   end

   assign rsp_valid    = vo_ff;
   assign rsp_res_real = ore_ff;
   assign rsp_res_imag = oim_ff;
   assign rsp_status   = ost_ff;
endmodule

### rtl/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
`timescale 1ns / 1ps
module cau_div (
   input  logic                             clock,
   input  logic [cau_pkg::NumW-1:0]         num_re_in,
   input  logic [cau_pkg::NumW-1:0]         num_im_in,
   input  logic [cau_pkg::DenW-1:0]         den_in,
   output logic [cau_pkg::QuoW-1:0]         quo_re,
   output logic [cau_pkg::QuoW-1:0]         quo_im
);
   localparam int N  = cau_pkg::QuoW;
   localparam int RW = cau_pkg::DenW + 1;

   logic [RW-1:0]            rem_re_ff [N];
   logic [RW-1:0]            rem_im_ff [N];
   logic [N-1:0]             q_re_ff   [N];
   logic [N-1:0]             q_im_ff   [N];
   logic [cau_pkg::DenW-1:0] den_ff    [N];

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [RW-1:0]            rre_in, rim_in;
      logic [N-1:0]             qre_in, qim_in;
      logic [cau_pkg::DenW-1:0] dv_in;
      logic [RW-1:0]            tre_in, tim_in;
      logic [RW:0]              dre_in, dim_in;
      if (s == 0) begin : g_first
         assign rre_in = '0;
         assign rim_in = '0;
         assign qre_in = num_re_in;
         assign qim_in = num_im_in;
         assign dv_in  = den_in;
      end else begin : g_next
         assign rre_in = rem_re_ff[s-1];
         assign rim_in = rem_im_ff[s-1];
         assign qre_in = q_re_ff[s-1];
         assign qim_in = q_im_ff[s-1];
         assign dv_in  = den_ff[s-1];
      end
      always_comb begin
         tre_in = {rre_in[RW-2:0], qre_in[N-1]};
         tim_in = {rim_in[RW-2:0], qim_in[N-1]};
         dre_in = {1'b0, tre_in} - {2'b0, dv_in};
         dim_in = {1'b0, tim_in} - {2'b0, dv_in};
      end
      always_ff @(posedge clock) begin
         rem_re_ff[s] <= dre_in[RW] ? tre_in : dre_in[RW-1:0];
         rem_im_ff[s] <= dim_in[RW] ? tim_in : dim_in[RW-1:0];
         q_re_ff[s]   <= {qre_in[N-2:0], ~dre_in[RW]};
         q_im_ff[s]   <= {qim_in[N-2:0], ~dim_in[RW]};
         den_ff[s]    <= dv_in;
      end
   end

   assign quo_re = q_re_ff[N-1];
   assign quo_im = q_im_ff[N-1];
endmodule

### tb/tb_top.sv
// Self-checking testbench for the complex ALU: directed table plus random transactions.
`timescale 1ns / 1ps
module tb_top;
   localparam int LATENCY = 45;

   typedef struct packed {
      logic [15:0] re;
      logic [15:0] im;
      logic [1:0]  st;
   } cplx_result_type;

   typedef struct {
      cau_pkg::op_type op;
      logic [15:0]     ar, ai, br, bi;
      bit              has_known;
      cplx_result_type known;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_mode = '0;
   logic signed [15:0] req_a_real = '0, req_a_imag = '0, req_b_real = '0, req_b_imag = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_res_real, rsp_res_imag;
   logic [1:0] rsp_status;

   cplx_result_type pending_results[$];
   int errors = 0;
   bit quiet_stretch = 0;
   stim_row_type rows[$];

   complex_arith_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_res_real(rsp_res_real),
      .rsp_res_imag(rsp_res_imag), .rsp_status(rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [15:0] clamp16(input longint v, inout bit clipped);
      if (v > 32767) begin
         clipped = 1;
         return 16'h7fff;
      end
      if (v < -32768) begin
         clipped = 1;
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   function automatic cplx_result_type compute_cplx(input cau_pkg::op_type op,
         input logic signed [15:0] ar, ai, br, bi);
      longint re, im, den;
      bit clipped;
      cplx_result_type r;
      clipped = 0;
      case (op)
         cau_pkg::OP_ADD: begin
            re = ar + br; im = ai + bi;
         end
         cau_pkg::OP_SUB: begin
            re = longint'(ar) - br; im = longint'(ai) - bi;
         end
         cau_pkg::OP_MUL: begin
            re = (longint'(ar) * br - longint'(ai) * bi) >>> cau_pkg::FracBits;
            im = (longint'(ar) * bi + longint'(ai) * br) >>> cau_pkg::FracBits;
         end
         default: begin
            den = longint'(br) * br + longint'(bi) * bi;
            if (den == 0) begin
               r.re = '0; r.im = '0; r.st = cau_pkg::ST_DIV0;
               return r;
            end
            // longint division truncates toward zero
            re = ((longint'(ar) * br + longint'(ai) * bi) * (64'sd1 <<< cau_pkg::FracBits))
                 / den;
            im = ((longint'(ai) * br - longint'(ar) * bi) * (64'sd1 <<< cau_pkg::FracBits))
                 / den;
         end
      endcase
      r.re = clamp16(re, clipped);
      r.im = clamp16(im, clipped);
      r.st = clipped ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      return r;
   endfunction

   task automatic add_row(cau_pkg::op_type op, logic [15:0] ar, ai, br, bi,
         bit known_ok = 0, logic [15:0] kre = 0, logic [15:0] kim = 0,
         logic [1:0] kst = 0);
      stim_row_type s;
      s.op = op; s.ar = ar; s.ai = ai; s.br = br; s.bi = bi;
      s.has_known = known_ok;
      s.known.re = kre; s.known.im = kim; s.known.st = kst;
      rows.push_back(s);
   endtask

   // drive one transaction; hold start until the block takes it
   task automatic issue(input stim_row_type s);
      cplx_result_type expv;
      while (!quiet_stretch && $urandom_range(99) < 6) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= s.op;
      req_a_real <= s.ar; req_a_imag <= s.ai;
      req_b_real <= s.br; req_b_imag <= s.bi;
      do @(posedge clock); while (busy);
      expv = s.has_known ? s.known : compute_cplx(s.op, s.ar, s.ai, s.br, s.bi);
      pending_results.push_back(expv);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result re=%h im=%h st=%0d", $time,
                     rsp_res_real, rsp_res_imag, rsp_status);
            errors++;
         end else begin
            cplx_result_type e;
            e = pending_results.pop_front();
            if (rsp_res_real !== e.re || rsp_res_imag !== e.im || rsp_status !== e.st) begin
               $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                        $time, e.re, e.im, e.st, rsp_res_real, rsp_res_imag, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type s;
      int waited;
      add_row(cau_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1,
              16'h0000, 16'h0000, cau_pkg::ST_OK);
      add_row(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1,
              16'h7fff, 16'h8000, cau_pkg::ST_SAT);
      add_row(cau_pkg::OP_ADD, 16'h7fff, 16'h0001, 16'h0000, 16'h0002);
      add_row(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1,
              16'h8000, 16'h7fff, cau_pkg::ST_SAT);
      add_row(cau_pkg::OP_SUB, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1,
              16'h0000, 16'h0000, cau_pkg::ST_OK);
      add_row(cau_pkg::OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1,
              16'h0100, 16'h0000, cau_pkg::ST_OK);
      add_row(cau_pkg::OP_MUL, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 1,
              16'hff00, 16'h0000, cau_pkg::ST_OK);
      add_row(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_row(cau_pkg::OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
      add_row(cau_pkg::OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
      add_row(cau_pkg::OP_DIV, 16'h1234, 16'hbeef, 16'h0000, 16'h0000, 1,
              16'h0000, 16'h0000, cau_pkg::ST_DIV0);
      add_row(cau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1,
              16'h0000, 16'h0000, cau_pkg::ST_DIV0);
      add_row(cau_pkg::OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1,
              16'h0100, 16'h0000, cau_pkg::ST_OK);
      add_row(cau_pkg::OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
      add_row(cau_pkg::OP_DIV, 16'hffff, 16'h0001, 16'h0003, 16'hfffd);
      add_row(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_row(cau_pkg::OP_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) issue(rows[i]);
      for (int n = 0; n < 600; n++) begin
         quiet_stretch = (n >= 250 && n < 400);
         s.op = cau_pkg::op_type'($urandom_range(3));
         s.has_known = 0;
         // mix small magnitudes with full range so results avoid always clipping
         if ($urandom_range(1)) begin
            s.ar = 16'($urandom()); s.ai = 16'($urandom());
            s.br = 16'($urandom()); s.bi = 16'($urandom());
         end else begin
            s.ar = 16'($signed($urandom_range(2047)) - 1024);
            s.ai = 16'($signed($urandom_range(2047)) - 1024);
            s.br = 16'($signed($urandom_range(2047)) - 1024);
            s.bi = 16'($signed($urandom_range(2047)) - 1024);
         end
         if ($urandom_range(19) == 0) begin
            s.br = '0; s.bi = '0;
         end
         issue(s);
      end
      start <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 10 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("[complex_arith_unit] OK");
      else
         $display("[complex_arith_unit] ERROR");
      $finish;
   end

   initial begin
      #200000;
      $display("[complex_arith_unit] ERROR");
      $finish;
   end
endmodule
